@@ rtl/core/md5sh_pkg.sv @@
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and table functions for the streaming MD5 core.
// ----------------------------------------------------------------------------
package md5sh_pkg;

   localparam int WORD_BITS = 32;
   localparam logic [6:0] BLOCK_BYTES = 7'd64;
   localparam logic [5:0] PAD_LIMIT = 6'd56;
   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [3:0] LEN_WORD_LO = 4'd14;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef word_type chain_type [4];

   // block padding control for the word fetch path
   typedef struct packed {
      logic [6:0] keep;     // bytes below this index come from the buffer
      logic       mark;     // the byte at keep is the 0x80 marker
      logic       len_blk;  // words 14 and 15 hold the bit length
   } pad_ctrl_type;

   localparam word_type INIT_VECTOR [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam word_type ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by a round
   function automatic logic [3:0] word_pick(input logic [5:0] round);
      logic [3:0] r4;
      logic [3:0] pick;
      r4 = round[3:0];
      case (round[5:4])
         2'd0: pick = r4;
         2'd1: pick = 4'((r4 << 2) + r4 + 4'd1);
         2'd2: pick = 4'((r4 << 1) + r4 + 4'd5);
         2'd3: pick = 4'((r4 << 3) - r4);
         default: pick = r4;
      endcase
      return pick;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] round);
      return ROT_TABLE[{round[5:4], round[1:0]}];
   endfunction

endpackage

@@ rtl/core/md5_stream_hash.sv @@
// ----------------------------------------------------------------------------
// md5_stream_hash
// Streaming MD5 digest of a byte stream, one shared round unit.
// ----------------------------------------------------------------------------
// Items are accepted while the core is idle. An item that completes a 64-byte
// block or ends the message starts a compression: chain load, 64 rounds
// through the single round unit, chain fold. The end of a message adds one
// padded compression, or two when 56 or more bytes of the last block are
// held, and then four digest words, one per cycle while rsp_tready is high.
// The message word for each round is fetched from the block memory one round
// ahead. req_tready is high only while no block is being compressed and no
// digest is waiting.
module md5_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [1:0]  rsp_tuser,   // [1:0] word_index
   output logic        rsp_tlast    // last_word
);
   import md5sh_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_ROUND = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [5:0]   round_ff, round_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  length_ff, length_in;
   logic [1:0]   out_idx_ff, out_idx_in;
   logic         eom_ff, eom_in;
   pad_ctrl_type pad_ff, pad_in;
   word_type     chain_ff [4];
   word_type     chain_in [4];
   word_type     work_ff [4];
   word_type     work_in [4];

   logic         accept;
   logic         has_byte;
   logic [5:0]   fill_new;
   logic [5:0]   rd_round;
   logic [31:0]  msg_word;
   word_type     rnd_out [4];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign has_byte   = req_tuser[0];
   assign fill_new   = has_byte ? fill_ff + 6'd1 : fill_ff;
   assign rd_round   = (state_ff == S_LOAD) ? 6'd0 : round_ff + 6'd1;

   md5sh_buffer u_buffer (
      .clock    (clock),
      .wr_en    (accept && has_byte),
      .wr_addr  (fill_ff),
      .wr_byte  (req_tdata),
      .rd_addr  (word_pick(rd_round)),
      .pad_ctrl (pad_ff),
      .len_bits ({length_ff[60:0], 3'b000}),
      .rd_word  (msg_word)
   );

   md5sh_round u_round (
      .round      (round_ff),
      .a_in_word  (work_ff[0]),
      .b_in_word  (work_ff[1]),
      .c_in_word  (work_ff[2]),
      .d_in_word  (work_ff[3]),
      .msg_word   (msg_word),
      .a_out_word (rnd_out[0]),
      .b_out_word (rnd_out[1]),
      .c_out_word (rnd_out[2]),
      .d_out_word (rnd_out[3])
   );

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      fill_in    = fill_ff;
      length_in  = length_ff;
      out_idx_in = out_idx_ff;
      eom_in     = eom_ff;
      pad_in     = pad_ff;
      chain_in   = chain_ff;
      work_in    = work_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fill_in = fill_new;
               if (has_byte) begin
                  length_in = length_ff + 64'd1;
               end
               if (has_byte && (fill_ff == LAST_ROUND)) begin
                  pad_in.keep    = BLOCK_BYTES;
                  pad_in.mark    = 1'b0;
                  pad_in.len_blk = 1'b0;
                  eom_in         = req_tlast;
                  state_in       = S_LOAD;
               end else if (req_tlast) begin
                  pad_in.keep    = {1'b0, fill_new};
                  pad_in.mark    = 1'b1;
                  pad_in.len_blk = (fill_new < PAD_LIMIT);
                  state_in       = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            work_in  = chain_ff;
            round_in = 6'd0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            work_in  = rnd_out;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int k = 0; k < 4; k++) begin
               chain_in[k] = chain_ff[k] + work_ff[k];
            end
            if (eom_ff) begin
               // full block ended the message: padding block follows
               pad_in.keep    = {1'b0, fill_ff};
               pad_in.mark    = 1'b1;
               pad_in.len_blk = (fill_ff < PAD_LIMIT);
               eom_in         = 1'b0;
               state_in       = S_LOAD;
            end else if (pad_ff.mark && !pad_ff.len_blk) begin
               // marker block had no room for the length
               pad_in.keep    = 7'd0;
               pad_in.mark    = 1'b0;
               pad_in.len_blk = 1'b1;
               state_in       = S_LOAD;
            end else if (pad_ff.len_blk) begin
               out_idx_in = 2'd0;
               state_in   = S_OUT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               out_idx_in = out_idx_ff + 2'd1;
               if (out_idx_ff == 2'd3) begin
                  chain_in  = INIT_VECTOR;
                  fill_in   = 6'd0;
                  length_in = 64'd0;
                  pad_in    = '0;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         round_ff   <= 6'd0;
         fill_ff    <= 6'd0;
         length_ff  <= 64'd0;
         out_idx_ff <= 2'd0;
         eom_ff     <= 1'b0;
         pad_ff     <= '0;
         chain_ff   <= INIT_VECTOR;
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         fill_ff    <= fill_in;
         length_ff  <= length_in;
         out_idx_ff <= out_idx_in;
         eom_ff     <= eom_in;
         pad_ff     <= pad_in;
         chain_ff   <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = chain_ff[out_idx_ff];
   assign rsp_tuser  = out_idx_ff;
   assign rsp_tlast  = (out_idx_ff == 2'd3);

endmodule

@@ rtl/core/md5sh_round.sv @@
// ----------------------------------------------------------------------------
// md5sh_round
// One MD5 round: boolean function, four-way add, rotate and add.
// ----------------------------------------------------------------------------
module md5sh_round (
   input  logic [5:0]  round,
   input  logic [31:0] a_in_word,
   input  logic [31:0] b_in_word,
   input  logic [31:0] c_in_word,
   input  logic [31:0] d_in_word,
   input  logic [31:0] msg_word,
   output logic [31:0] a_out_word,
   output logic [31:0] b_out_word,
   output logic [31:0] c_out_word,
   output logic [31:0] d_out_word
);
   import md5sh_pkg::*;

   logic [31:0] f_val;
   logic [31:0] sum;
   logic [31:0] rotated;
   logic [5:0]  shift;

   always_comb begin
      case (round[5:4])
         2'd0: f_val = (b_in_word & c_in_word) | (~b_in_word & d_in_word);
         2'd1: f_val = (d_in_word & b_in_word) | (~d_in_word & c_in_word);
         2'd2: f_val = b_in_word ^ c_in_word ^ d_in_word;
         2'd3: f_val = c_in_word ^ (b_in_word | ~d_in_word);
         default: f_val = b_in_word ^ c_in_word ^ d_in_word;
      endcase
   end

   assign sum     = f_val + a_in_word + ROUND_K[round] + msg_word;
   assign shift   = {1'b0, rot_amount(round)};
   assign rotated = (sum << shift) | (sum >> (6'd32 - shift));

   assign a_out_word = d_in_word;
   assign b_out_word = b_in_word + rotated;
   assign c_out_word = b_in_word;
   assign d_out_word = c_in_word;

endmodule

@@ rtl/core/md5sh_buffer.sv @@
// ----------------------------------------------------------------------------
// md5sh_buffer
// 64-byte block memory, byte writes and registered word reads, with the
// padding bytes and bit length merged into the fetched word.
// ----------------------------------------------------------------------------
module md5sh_buffer (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [5:0]                wr_addr,
   input  logic [7:0]                wr_byte,
   input  logic [3:0]                rd_addr,
   input  md5sh_pkg::pad_ctrl_type   pad_ctrl,
   input  logic [63:0]               len_bits,
   output logic [31:0]               rd_word
);
   import md5sh_pkg::*;

   logic [31:0] block_mem_ff [16];
   logic [31:0] rd_data_ff;
   logic [3:0]  rd_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem_ff[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      rd_data_ff <= block_mem_ff[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   always_comb begin
      logic [5:0] pos;
      for (int j = 0; j < 4; j++) begin
         pos = {rd_idx_ff, 2'(j)};
         if ({1'b0, pos} < pad_ctrl.keep) begin
            rd_word[8*j +: 8] = rd_data_ff[8*j +: 8];
         end else if (pad_ctrl.mark && ({1'b0, pos} == pad_ctrl.keep)) begin
            rd_word[8*j +: 8] = PAD_MARKER;
         end else if (pad_ctrl.len_blk && (rd_idx_ff >= LEN_WORD_LO)) begin
            rd_word[8*j +: 8] = len_bits[{pos[2:0], 3'b000} +: 8];
         end else begin
            rd_word[8*j +: 8] = 8'h00;
         end
      end
   end

endmodule
